[design/ukt_pkg.sv]
package ukt_pkg;

    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_BYTES  = 8;

    localparam int MAX_ID_LEN = SLOT_BYTES - 1;
    localparam int ID_W       = 8 * MAX_ID_LEN;
    localparam int LEN_W      = $clog2(SLOT_BYTES);
    localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;

    localparam int KIND_W   = 2;
    localparam int CARD_W   = 56;
    localparam int IDLEN_W  = 8;
    localparam int STATUS_W = 3;
    localparam int SLOTOUT_W = 4;

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

    // request held for the whole scan
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic              len_ok;
    } ukt_req_t;

    // scan token handed from cell to cell
    typedef struct packed {
        logic              active;
        logic              match_found;
        logic [SLOT_W-1:0] match_idx;
        logic              free_found;
        logic [SLOT_W-1:0] free_idx;
    } ukt_tok_t;

    // write-back broadcast at the end of the scan
    typedef struct packed {
        logic              fill;
        logic              free;
        logic              clear_all;
        logic [SLOT_W-1:0] target;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
    } ukt_wr_t;

endpackage

[design/uid_key_table.sv]
// uid_key_table: table of card identifiers, one slot per cell of a chain
//
// input: a transaction is taken when start is high and busy is low; kind
// selects add, delete, lookup or clear, card_id holds the identifier bytes
// (byte 0 lowest) and id_length the byte count
// output: done is high for one cycle with status, hit and slot valid; the
// receiver cannot stall, so the result must be taken in that cycle
// latency: a scan token walks the chain one slot per cycle, then the table
// is written back and the result registered: done rises TABLE_SLOTS + 1
// cycles after accept (17 cycles with 16 slots)
// throughput: one transaction per TABLE_SLOTS + 2 cycles; busy stays high
// from accept until done is raised, set by the length of the cell chain
// add fills the lowest free slot, delete and lookup report the lowest
// matching slot, clear frees every slot
// reset: all slots free, no transaction in flight, done low
module uid_key_table (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ukt_pkg::KIND_W-1:0]      kind,
    input  logic [ukt_pkg::CARD_W-1:0]      card_id,
    input  logic [ukt_pkg::IDLEN_W-1:0]     id_length,
    output logic                            done,
    output logic [ukt_pkg::STATUS_W-1:0]    status,
    output logic                            hit,
    output logic [ukt_pkg::SLOTOUT_W-1:0]   slot
);
    import ukt_pkg::*;

    logic                 busy_reg;
    logic                 inj_reg;
    logic                 done_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [STATUS_W-1:0]  status_next;
    logic                 hit_reg;
    logic                 hit_next;
    logic [SLOTOUT_W-1:0] slot_reg;
    logic [SLOTOUT_W-1:0] slot_next;
    ukt_req_t             req_reg;
    ukt_req_t             req_next;
    ukt_wr_t              wr;
    ukt_tok_t             tok_chain [TABLE_SLOTS+1];
    ukt_tok_t             fin;
    logic [TABLE_SLOTS:0] act_vec;
    logic                 accept;

    assign accept = start && !busy_reg;

    // masked request
    always_comb
    begin
        req_next.kind   = kind;
        req_next.len    = id_length[LEN_W-1:0];
        req_next.len_ok = (id_length <= IDLEN_W'(MAX_ID_LEN));
        for (int b = 0; b < MAX_ID_LEN; b++)
        begin
            req_next.id[8*b +: 8] = (id_length > IDLEN_W'(b)) ? card_id[8*b +: 8] : 8'd0;
        end
    end

    always_comb
    begin
        tok_chain[0]        = '0;
        tok_chain[0].active = inj_reg;
    end

    genvar g;
    generate
        for (g = 0; g < TABLE_SLOTS; g++)
        begin : g_cell
            ukt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (SLOT_W'(g)),
                .req      (req_reg),
                .wr       (wr),
                .tok_in   (tok_chain[g]),
                .tok_out  (tok_chain[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        for (int i = 0; i <= TABLE_SLOTS; i++)
        begin
            act_vec[i] = tok_chain[i].active;
        end
    end

    assign fin = tok_chain[TABLE_SLOTS];

    // decision and write-back at end of scan
    always_comb
    begin
        wr.fill      = 1'b0;
        wr.free      = 1'b0;
        wr.clear_all = 1'b0;
        wr.target    = fin.match_idx;
        wr.id        = req_reg.id;
        wr.len       = req_reg.len;
        status_next  = ST_OK;
        hit_next     = 1'b0;
        slot_next    = '0;
        unique case (req_reg.kind)
            KIND_ADD:
            begin
                priority if (!req_reg.len_ok)
                begin
                    status_next = ST_TOO_LONG;
                end
                else if (fin.match_found)
                begin
                    status_next = ST_DUPLICATE;
                end
                else if (!fin.free_found)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    wr.fill   = fin.active;
                    wr.target = fin.free_idx;
                    slot_next = SLOTOUT_W'(fin.free_idx);
                end
            end
            KIND_DELETE, KIND_LOOKUP:
            begin
                if (fin.match_found)
                begin
                    hit_next  = 1'b1;
                    slot_next = SLOTOUT_W'(fin.match_idx);
                    wr.free   = fin.active && (req_reg.kind == KIND_DELETE);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
            KIND_CLEAR:
            begin
                wr.clear_all = fin.active;
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            inj_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            inj_reg  <= accept;
            done_reg <= fin.active;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (fin.active)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_next;
        end
        if (fin.active)
        begin
            status_reg <= status_next;
            hit_reg    <= hit_next;
            slot_reg   <= slot_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign status = status_reg;
    assign hit    = hit_reg;
    assign slot   = slot_reg;

    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(act_vec))
        else $error("more than one scan token in the chain");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("busy not raised after accept");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("result shown while still busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("result without a transaction");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && hit_reg) |-> (status_reg == ST_OK))
        else $error("hit with failing status");

endmodule

[design/ukt_cell.sv]
module ukt_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [ukt_pkg::SLOT_W-1:0] cell_idx,
    input  ukt_pkg::ukt_req_t        req,
    input  ukt_pkg::ukt_wr_t         wr,
    input  ukt_pkg::ukt_tok_t        tok_in,
    output ukt_pkg::ukt_tok_t        tok_out
);
    import ukt_pkg::*;

    logic             valid_reg;
    logic [ID_W-1:0]  id_reg;
    logic [LEN_W-1:0] len_reg;
    logic             hit_here;
    logic             target_here;
    ukt_tok_t         tok_reg;
    ukt_tok_t         tok_next;

    assign hit_here = valid_reg && req.len_ok && (len_reg == req.len) && (id_reg == req.id);
    assign target_here = (wr.target == cell_idx);

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.active && !tok_in.match_found && hit_here)
        begin
            tok_next.match_found = 1'b1;
            tok_next.match_idx   = cell_idx;
        end
        if (tok_in.active && !tok_in.free_found && !valid_reg)
        begin
            tok_next.free_found = 1'b1;
            tok_next.free_idx   = cell_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
            priority if (wr.clear_all)
            begin
                valid_reg <= 1'b0;
            end
            else if (wr.fill && target_here)
            begin
                valid_reg <= 1'b1;
            end
            else if (wr.free && target_here)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                valid_reg <= valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.fill && target_here)
        begin
            id_reg  <= wr.id;
            len_reg <= wr.len;
        end
    end

    assign tok_out = tok_reg;

endmodule
